[design/nmec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmec_pkg
// shared types, constants and helpers for the mesh edge crossing checker
// ----------------------------------------------------------------------------
package nmec_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int MAX_ENTRIES = 8192;
  localparam int MAX_DEGREE  = 16;
  localparam int COORD_W     = 16;
  localparam int NODE_W      = 11;
  localparam int NODE_AW     = $clog2(MAX_NODES);
  localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int DEG_W       = 5;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;

  localparam logic [1:0] KIND_NODE  = 2'd0;
  localparam logic [1:0] KIND_ADJ   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DEG_W-1:0]          deg;
    logic [ENTRY_AW-1:0]       start;
  } node_row_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
  } cross_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } cross_stat_t;

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    node_ok = (n != '0) && (n <= NODE_W'(MAX_NODES));
  endfunction

  function automatic logic [DEG_W-1:0] deg_clamp(input logic [DEG_W-1:0] d);
    deg_clamp = (d > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : d;
  endfunction

  function automatic logic [NODE_AW-1:0] node_addr(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n - NODE_W'(1);
    node_addr = m[NODE_AW-1:0];
  endfunction

endpackage

[design/nmec_node_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmec_node_ram
// node table: coordinates, degree and list start, one row per node
// ----------------------------------------------------------------------------
module nmec_node_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [nmec_pkg::NODE_AW-1:0] waddr,
  input  nmec_pkg::node_row_t     wdata,
  input  logic [nmec_pkg::NODE_AW-1:0] raddr,
  output nmec_pkg::node_row_t     rdata
);
  import nmec_pkg::*;

  node_row_t mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/nmec_adj_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmec_adj_ram
// adjacency table of one-based neighbour numbers
// ----------------------------------------------------------------------------
module nmec_adj_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [nmec_pkg::ENTRY_AW-1:0] waddr,
  input  logic [nmec_pkg::NODE_W-1:0]   wdata,
  input  logic [nmec_pkg::ENTRY_AW-1:0] raddr,
  output logic [nmec_pkg::NODE_W-1:0]   rdata
);
  import nmec_pkg::*;

  logic [NODE_W-1:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/nmec_cross.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmec_cross
// three stage segment crossing test by cross product sign checks
// ----------------------------------------------------------------------------
module nmec_cross (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  nmec_pkg::cross_req_t req,
  output nmec_pkg::cross_stat_t stat
);
  import nmec_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic signed [DIFF_W-1:0] a_r, b_r, c_r, d_r, e_r, f_r;
  logic signed [PROD_W-1:0] ad_r, cb_r, de_r, bf_r, af_r, ce_r;
  logic hit_r;
  logic signed [SUM_W-1:0] det, sn, tn;
  logic hit_nxt;

  always_comb begin
    det = SUM_W'(ad_r) - SUM_W'(cb_r);
    sn  = SUM_W'(de_r) - SUM_W'(bf_r);
    tn  = SUM_W'(af_r) - SUM_W'(ce_r);
    if (det > 0) begin
      hit_nxt = (sn > 0) && (tn > 0) && (sn < det) && (tn < det);
    end else if (det < 0) begin
      hit_nxt = (sn < 0) && (tn < 0) && (sn > det) && (tn > det);
    end else begin
      hit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    a_r <= DIFF_W'(req.lx) - DIFF_W'(req.cx);
    b_r <= DIFF_W'(req.nx) - DIFF_W'(req.mx);
    c_r <= DIFF_W'(req.ly) - DIFF_W'(req.cy);
    d_r <= DIFF_W'(req.ny) - DIFF_W'(req.my);
    e_r <= DIFF_W'(req.nx) - DIFF_W'(req.cx);
    f_r <= DIFF_W'(req.ny) - DIFF_W'(req.cy);
    ad_r <= a_r * d_r;
    cb_r <= c_r * b_r;
    de_r <= d_r * e_r;
    bf_r <= b_r * f_r;
    af_r <= a_r * f_r;
    ce_r <= c_r * e_r;
    hit_r <= hit_nxt;
  end

  assign stat.busy = v1_r | v2_r | v3_r;
  assign stat.done = v3_r;
  assign stat.hit  = hit_r;

endmodule

[design/mesh_neighborhood_edge_crossing.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_neighborhood_edge_crossing
// loads node and adjacency tables, answers edge crossing queries per node
// ----------------------------------------------------------------------------
// load transactions are taken whenever idle and give no result
// query time is set by the table walk: a tested edge pair costs adjacency
// and node reads and the three stage crossing unit, a skipped one its adjacency
// read, plus both reads per neighbour c, n or m visited; up to degree^4 pairs
// one query in flight at a time, early exit on hit; result register frees input
// synchronous active low reset clears control only, tables hold no reset
module mesh_neighborhood_edge_crossing (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [nmec_pkg::NODE_W-1:0]   in_node_number,
  input  logic signed [nmec_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [nmec_pkg::COORD_W-1:0] in_y_coord,
  input  logic [nmec_pkg::DEG_W-1:0]    in_degree,
  input  logic [nmec_pkg::ENTRY_AW-1:0] in_list_start,
  input  logic [nmec_pkg::ENTRY_AW-1:0] in_entry_index,
  input  logic [nmec_pkg::NODE_W-1:0]   in_neighbour_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_crossing_found
);
  import nmec_pkg::*;

  typedef enum logic [4:0] {
    IDLE, Q_RD, Q_WT, T_I, C_ARD, C_AWT, C_NRD, C_NWT, T_J,
    N_ARD, N_AWT, N_NRD, N_NWT, T_K, M_ARD, M_AWT, M_NRD, M_NWT,
    T_L, L_ARD, L_AWT, L_NRD, L_NWT, X_WT, DONE
  } state_t;

  state_t state_r;
  logic [NODE_W-1:0] q_r, cn_r, nn_r, mm_r, ll_r;
  logic [DEG_W-1:0] i_r, j_r, k_r, l_r, dq_r, dc_r, dn_r;
  logic [ENTRY_AW-1:0] sq_r, sc_r, sn_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, nx_r, ny_r, mx_r, my_r;
  logic found_r, out_valid_r, out_found_r;

  logic in_acc;
  logic node_we, adj_we;
  node_row_t node_wdata, node_rdata;
  logic [NODE_AW-1:0] node_raddr;
  logic [ENTRY_AW-1:0] adj_raddr;
  logic [NODE_W-1:0] adj_rdata;
  logic x_start;
  cross_req_t x_req;
  cross_stat_t x_stat;
  logic l_skip;

  assign in_ready = (state_r == IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_crossing_found = out_found_r;

  assign node_we = in_acc && (in_kind == KIND_NODE) && node_ok(in_node_number);
  assign adj_we  = in_acc && (in_kind == KIND_ADJ);
  assign node_wdata = '{x: in_x_coord, y: in_y_coord, deg: in_degree,
                        start: in_list_start};

  always_comb begin
    case (state_r)
      C_NRD:   node_raddr = node_addr(cn_r);
      N_NRD:   node_raddr = node_addr(nn_r);
      M_NRD:   node_raddr = node_addr(mm_r);
      L_NRD:   node_raddr = node_addr(ll_r);
      default: node_raddr = node_addr(q_r);
    endcase
    case (state_r)
      C_ARD:   adj_raddr = sq_r + ENTRY_AW'(i_r);
      N_ARD:   adj_raddr = sc_r + ENTRY_AW'(j_r);
      M_ARD:   adj_raddr = sn_r + ENTRY_AW'(k_r);
      default: adj_raddr = sc_r + ENTRY_AW'(l_r);
    endcase
  end

  assign l_skip = !node_ok(adj_rdata) || (cn_r == nn_r) || (cn_r == mm_r) ||
                  (adj_rdata == nn_r) || (adj_rdata == mm_r);

  assign x_start = (state_r == L_NWT);
  assign x_req = '{cx: cx_r, cy: cy_r, lx: node_rdata.x, ly: node_rdata.y,
                   nx: nx_r, ny: ny_r, mx: mx_r, my: my_r};

  nmec_node_ram u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_addr(in_node_number)),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  nmec_adj_ram u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (in_entry_index),
    .wdata (in_neighbour_number),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  nmec_cross u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .start (x_start),
    .req   (x_req),
    .stat  (x_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (in_acc && (in_kind == KIND_QUERY)) begin
            q_r     <= in_node_number;
            found_r <= 1'b0;
            state_r <= node_ok(in_node_number) ? Q_RD : DONE;
          end
        end
        Q_RD: state_r <= Q_WT;
        Q_WT: begin
          dq_r <= deg_clamp(node_rdata.deg);
          sq_r <= node_rdata.start;
          i_r <= '0;
          state_r <= T_I;
        end
        T_I: state_r <= (i_r < dq_r) ? C_ARD : DONE;
        C_ARD: state_r <= C_AWT;
        C_AWT: begin
          cn_r <= adj_rdata;
          if (node_ok(adj_rdata)) begin
            state_r <= C_NRD;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= T_I;
          end
        end
        C_NRD: state_r <= C_NWT;
        C_NWT: begin
          cx_r <= node_rdata.x;
          cy_r <= node_rdata.y;
          dc_r <= deg_clamp(node_rdata.deg);
          sc_r <= node_rdata.start;
          j_r <= '0;
          state_r <= T_J;
        end
        T_J: begin
          if (j_r < dc_r) begin
            state_r <= N_ARD;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= T_I;
          end
        end
        N_ARD: state_r <= N_AWT;
        N_AWT: begin
          nn_r <= adj_rdata;
          if (node_ok(adj_rdata)) begin
            state_r <= N_NRD;
          end else begin
            j_r <= j_r + 1'b1;
            state_r <= T_J;
          end
        end
        N_NRD: state_r <= N_NWT;
        N_NWT: begin
          nx_r <= node_rdata.x;
          ny_r <= node_rdata.y;
          dn_r <= deg_clamp(node_rdata.deg);
          sn_r <= node_rdata.start;
          k_r <= '0;
          state_r <= T_K;
        end
        T_K: begin
          if (k_r < dn_r) begin
            state_r <= M_ARD;
          end else begin
            j_r <= j_r + 1'b1;
            state_r <= T_J;
          end
        end
        M_ARD: state_r <= M_AWT;
        M_AWT: begin
          mm_r <= adj_rdata;
          if (node_ok(adj_rdata)) begin
            state_r <= M_NRD;
          end else begin
            k_r <= k_r + 1'b1;
            state_r <= T_K;
          end
        end
        M_NRD: state_r <= M_NWT;
        M_NWT: begin
          mx_r <= node_rdata.x;
          my_r <= node_rdata.y;
          l_r <= '0;
          state_r <= T_L;
        end
        T_L: begin
          if (l_r < dc_r) begin
            state_r <= L_ARD;
          end else begin
            k_r <= k_r + 1'b1;
            state_r <= T_K;
          end
        end
        L_ARD: state_r <= L_AWT;
        L_AWT: begin
          ll_r <= adj_rdata;
          if (l_skip) begin
            l_r <= l_r + 1'b1;
            state_r <= T_L;
          end else begin
            state_r <= L_NRD;
          end
        end
        L_NRD: state_r <= L_NWT;
        L_NWT: state_r <= X_WT;
        X_WT: begin
          if (x_stat.done) begin
            if (x_stat.hit) begin
              found_r <= 1'b1;
              state_r <= DONE;
            end else begin
              l_r <= l_r + 1'b1;
              state_r <= T_L;
            end
          end
        end
        DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= found_r;
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idle_cross: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !x_stat.busy)
    else $error("crossing unit busy while idle");

  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    x_stat.done |-> (state_r == X_WT))
    else $error("crossing result outside wait state");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == KIND_QUERY)) |=> (state_r != IDLE))
    else $error("query transaction did not start");

  a_lx_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == X_WT) && x_stat.done |-> (ll_r != nn_r) && (ll_r != mm_r))
    else $error("shared vertex pair reached crossing unit");
`endif

endmodule
